// ===== hw/rtl/dasd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasd_pkg: shared types and calendar helpers
// Field widths, default parameter values, the datapath operation codes and
// the calendar functions used by the datapath.
// ----------------------------------------------------------------------------
package dasd_pkg;

  localparam int YEAR_BITS        = 14;
  localparam int MONTH_BITS       = 4;
  localparam int DAY_BITS         = 5;
  localparam int DOY_BITS         = 9;
  localparam int CYC_BITS         = 9;

  localparam int OFFSET_BITS_DEF  = 21;
  localparam int YEAR_MAX_DEF     = 9999;

  localparam int FALLBACK_YEAR    = 2000;
  localparam int YEAR_CYCLE       = 400;
  localparam int FALLBACK_CYCLE   = FALLBACK_YEAR % YEAR_CYCLE;
  localparam int CENTURY          = 100;
  localparam int DAYS_COMMON      = 365;
  localparam int DAYS_LEAP        = 366;
  localparam int FEB_COMMON       = 28;
  localparam int FEB_LEAP         = 29;
  localparam int MONTHS           = 12;
  localparam int FEBRUARY         = 2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MOD,
    OP_CHECK,
    OP_YEAR,
    OP_MONTH,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic mod_done;
    logic year_done;
    logic year_err;
    logic month_done;
  } dp_status_t;

  // leap rule on the year taken modulo 400
  function automatic logic is_leap(input logic [CYC_BITS-1:0] cyc);
    logic by4;
    logic by100;
    by4   = (cyc[1:0] == 2'b00);
    by100 = (cyc == CYC_BITS'(CENTURY)) || (cyc == CYC_BITS'(2 * CENTURY)) ||
            (cyc == CYC_BITS'(3 * CENTURY));
    return by4 && !by100;
  endfunction

  function automatic logic [DOY_BITS-1:0] year_len(input logic leap);
    return leap ? DOY_BITS'(DAYS_LEAP) : DOY_BITS'(DAYS_COMMON);
  endfunction

  function automatic logic [DAY_BITS-1:0] month_days(input logic leap,
                                                     input logic [MONTH_BITS-1:0] m);
    logic [DAY_BITS-1:0] n;
    case (m)
      4'd2: begin
        n = leap ? DAY_BITS'(FEB_LEAP) : DAY_BITS'(FEB_COMMON);
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        n = DAY_BITS'(30);
      end
      default: begin
        n = DAY_BITS'(31);
      end
    endcase
    return n;
  endfunction

  // days before the month in a common year
  function automatic logic [DOY_BITS-1:0] month_start(input logic [MONTH_BITS-1:0] m);
    logic [DOY_BITS-1:0] s;
    case (m)
      4'd2:    s = DOY_BITS'(31);
      4'd3:    s = DOY_BITS'(59);
      4'd4:    s = DOY_BITS'(90);
      4'd5:    s = DOY_BITS'(120);
      4'd6:    s = DOY_BITS'(151);
      4'd7:    s = DOY_BITS'(181);
      4'd8:    s = DOY_BITS'(212);
      4'd9:    s = DOY_BITS'(243);
      4'd10:   s = DOY_BITS'(273);
      4'd11:   s = DOY_BITS'(304);
      4'd12:   s = DOY_BITS'(334);
      default: s = DOY_BITS'(0);
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/dasd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasd_in_if: request channel
// Valid/ready channel carrying the start date and the signed day offset.
// ----------------------------------------------------------------------------
interface dasd_in_if import dasd_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [YEAR_BITS-1:0]          start_year;
  logic [MONTH_BITS-1:0]         start_month;
  logic [DAY_BITS-1:0]           start_day;
  logic signed [OFFSET_BITS-1:0] day_offset;

  modport source (
    output valid, start_year, start_month, start_day, day_offset,
    input  ready
  );

  modport sink (
    input  valid, start_year, start_month, start_day, day_offset,
    output ready
  );
endinterface

// ===== hw/rtl/dasd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasd_out_if: result channel
// Valid/ready channel carrying the resulting date and the two flags.
// ----------------------------------------------------------------------------
interface dasd_out_if import dasd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [YEAR_BITS-1:0]  end_year;
  logic [MONTH_BITS-1:0] end_month;
  logic [DAY_BITS-1:0]   end_day;
  logic                  start_invalid;
  logic                  range_error;

  modport source (
    output valid, end_year, end_month, end_day, start_invalid, range_error,
    input  ready
  );

  modport sink (
    input  valid, end_year, end_month, end_day, start_invalid, range_error,
    output ready
  );
endinterface

// ===== hw/rtl/date_add_signed_days_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_signed_days_top: Gregorian date plus signed day offset
// Moves a start date by a signed number of days with full leap-year and
// month/year rollover handling.
// ----------------------------------------------------------------------------
// usage:
//   din carries start_year, start_month, start_day and a signed day_offset;
//   dout returns end_year, end_month, end_day, start_invalid, range_error.
//   one result transaction per request transaction, in order.
//   an invalid start date is replaced by 1/1/2000 and flagged; a result
//   outside years 0..YEAR_MAX returns the start date with range_error set.
//   from accept to result valid the request passes a load step, year
//   reduction mod 400, a check step, the year walk over each calendar
//   year crossed, the month walk and an output step.
//   the year walk steps one year per cycle.
//   one request is worked on at a time; din.ready is high only when idle.
//   the result sits in an output register; the next request is accepted
//   while it waits, and the finished result waits there if dout stalls.
//   synchronous reset returns to idle and drops dout.valid.
// ----------------------------------------------------------------------------
module date_add_signed_days_top import dasd_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int YEAR_MAX    = YEAR_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dasd_in_if.sink    din,
  dasd_out_if.source dout
);

  dp_op_t     op;
  dp_status_t status;

  dasd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_ready (dout.ready),
    .out_valid (dout.valid),
    .status    (status),
    .op        (op)
  );

  dasd_dp #(
    .OFFSET_BITS (OFFSET_BITS),
    .YEAR_MAX    (YEAR_MAX)
  ) u_dp (
    .clk           (clk),
    .op            (op),
    .start_year    (din.start_year),
    .start_month   (din.start_month),
    .start_day     (din.start_day),
    .day_offset    (din.day_offset),
    .status        (status),
    .end_year      (dout.end_year),
    .end_month     (dout.end_month),
    .end_day       (dout.end_day),
    .start_invalid (dout.start_invalid),
    .range_error   (dout.range_error)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |=> !din.ready)
    else $error("request accepted while busy");

  a_out_loads_valid: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT) |=> dout.valid)
    else $error("result register loaded without valid");

  a_month_legal: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> ((dout.end_month != '0) && (dout.end_month <= MONTH_BITS'(MONTHS))
                    && (dout.end_day != '0)))
    else $error("result month or day out of range");

endmodule

// ===== hw/rtl/dasd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasd_ctrl: sequencing state machine
// Steps the datapath through year reduction, validation, the year walk and
// the month walk, and owns the output valid flag.
// ----------------------------------------------------------------------------
module dasd_ctrl import dasd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        op = OP_MOD;
        if (status.mod_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        op         = OP_CHECK;
        state_next = S_YEAR;
      end
      S_YEAR: begin
        op = OP_YEAR;
        if (status.year_err) begin
          state_next = S_FINISH;
        end else if (status.year_done) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        op = OP_MONTH;
        if (status.month_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/dasd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasd_dp: date arithmetic datapath
// Holds the working date, the year phase in the 400-year cycle and the
// running day remainder; one year or one month per step, plus the result
// register.
// ----------------------------------------------------------------------------
module dasd_dp import dasd_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int YEAR_MAX    = YEAR_MAX_DEF
) (
  input  logic                          clk,
  input  dp_op_t                        op,
  input  logic [YEAR_BITS-1:0]          start_year,
  input  logic [MONTH_BITS-1:0]         start_month,
  input  logic [DAY_BITS-1:0]           start_day,
  input  logic signed [OFFSET_BITS-1:0] day_offset,
  output dp_status_t                    status,
  output logic [YEAR_BITS-1:0]          end_year,
  output logic [MONTH_BITS-1:0]         end_month,
  output logic [DAY_BITS-1:0]           end_day,
  output logic                          start_invalid,
  output logic                          range_error
);

  localparam int YMAX_BITS = $clog2(YEAR_MAX + 2);
  localparam int YW        = (YMAX_BITS > YEAR_BITS) ? YMAX_BITS : YEAR_BITS;
  localparam int RW        = ((OFFSET_BITS > DOY_BITS) ? OFFSET_BITS : DOY_BITS) + 2;
  localparam logic [YW-1:0] YMAX_W     = YW'(YEAR_MAX);
  localparam logic [YW-1:0] FALLBACK_W = YW'(FALLBACK_YEAR);

  logic [YEAR_BITS-1:0]          in_year;
  logic [MONTH_BITS-1:0]         in_month;
  logic [DAY_BITS-1:0]           in_day;
  logic signed [OFFSET_BITS-1:0] in_off;
  logic [YEAR_BITS-1:0]          ymod;
  logic [CYC_BITS-1:0]           cyc;
  logic [YW-1:0]                 sy;
  logic [YW-1:0]                 wy;
  logic [MONTH_BITS-1:0]         sm;
  logic [DAY_BITS-1:0]           sd;
  logic [MONTH_BITS-1:0]         mon;
  logic signed [RW-1:0]          r;
  logic                          inv;
  logic                          rng;

  logic                  start_ok;
  logic [DAY_BITS-1:0]   in_dim;
  logic [YW-1:0]         ch_year;
  logic [MONTH_BITS-1:0] ch_month;
  logic [DAY_BITS-1:0]   ch_day;
  logic [CYC_BITS-1:0]   ch_cyc;
  logic                  ch_leap;
  logic [DOY_BITS-1:0]   doy;
  logic signed [RW-1:0]  ch_r;
  logic                  neg;
  logic                  ge;
  logic [CYC_BITS-1:0]   cyc_prev;
  logic [CYC_BITS-1:0]   cyc_next;
  logic [DOY_BITS-1:0]   len_cur;
  logic [DOY_BITS-1:0]   len_prev;
  logic [DAY_BITS-1:0]   mdim;

  // start date check and day of year
  always_comb begin
    in_dim   = month_days(is_leap(ymod[CYC_BITS-1:0]), in_month);
    start_ok = (in_month != '0) && (in_month <= MONTH_BITS'(MONTHS)) &&
               (in_day != '0) && (YW'(in_year) <= YMAX_W) && (in_day <= in_dim);
    ch_year  = start_ok ? YW'(in_year) : FALLBACK_W;
    ch_month = start_ok ? in_month : MONTH_BITS'(1);
    ch_day   = start_ok ? in_day : DAY_BITS'(1);
    ch_cyc   = start_ok ? ymod[CYC_BITS-1:0] : CYC_BITS'(FALLBACK_CYCLE);
    ch_leap  = is_leap(ch_cyc);
    doy      = month_start(ch_month) + DOY_BITS'(ch_day) - DOY_BITS'(1) +
               DOY_BITS'(ch_leap && (ch_month > MONTH_BITS'(FEBRUARY)));
    ch_r     = RW'(doy) + RW'(in_off);
  end

  // year and month walk
  always_comb begin
    neg      = r[RW-1];
    len_cur  = year_len(is_leap(cyc));
    cyc_prev = (cyc == '0) ? CYC_BITS'(YEAR_CYCLE - 1) : cyc - CYC_BITS'(1);
    cyc_next = (cyc == CYC_BITS'(YEAR_CYCLE - 1)) ? '0 : cyc + CYC_BITS'(1);
    len_prev = year_len(is_leap(cyc_prev));
    ge       = !neg && (r >= RW'(len_cur));
    mdim     = month_days(is_leap(cyc), mon);
  end

  assign status.mod_done   = (ymod < YEAR_BITS'(YEAR_CYCLE));
  assign status.year_done  = !neg && !ge;
  assign status.year_err   = rng || (neg && (wy == '0)) || (ge && (wy == YMAX_W));
  assign status.month_done = (mon == MONTH_BITS'(MONTHS)) || (r < RW'(mdim));

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        in_year  <= start_year;
        in_month <= start_month;
        in_day   <= start_day;
        in_off   <= day_offset;
        ymod     <= start_year;
      end
      OP_MOD: begin
        if (!status.mod_done) begin
          ymod <= ymod - YEAR_BITS'(YEAR_CYCLE);
        end
      end
      OP_CHECK: begin
        sy  <= ch_year;
        wy  <= ch_year;
        sm  <= ch_month;
        sd  <= ch_day;
        cyc <= ch_cyc;
        r   <= ch_r;
        mon <= MONTH_BITS'(1);
        inv <= !start_ok;
        rng <= (ch_year > YMAX_W);
      end
      OP_YEAR: begin
        if (status.year_err) begin
          rng <= 1'b1;
        end else if (neg) begin
          wy  <= wy - YW'(1);
          cyc <= cyc_prev;
          r   <= r + RW'(len_prev);
        end else if (ge) begin
          wy  <= wy + YW'(1);
          cyc <= cyc_next;
          r   <= r - RW'(len_cur);
        end
      end
      OP_MONTH: begin
        if (!status.month_done) begin
          r   <= r - RW'(mdim);
          mon <= mon + MONTH_BITS'(1);
        end
      end
      OP_OUT: begin
        end_year      <= rng ? sy[YEAR_BITS-1:0] : wy[YEAR_BITS-1:0];
        end_month     <= rng ? sm : mon;
        end_day       <= rng ? sd : (r[DAY_BITS-1:0] + DAY_BITS'(1));
        start_invalid <= inv;
        range_error   <= rng;
      end
      default: begin
      end
    endcase
  end

endmodule
